>>> src/ilsort_pkg.sv
// Shared types and constants for the indexed list store with sort.
package ilsort_pkg;

   // Operation codes carried in a request beat.
   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_INSERT = 3'd2,
      OP_APPEND = 3'd3,
      OP_ERASE  = 3'd4,
      OP_POP    = 3'd5,
      OP_SORT   = 3'd6
   } op_type;

   // Status codes returned with every response beat.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CAPTURE,
      S_MOVE,
      S_PUT,
      S_SORT_FETCH,
      S_SORT_HOLD,
      S_SORT_CMP,
      S_SORT_PLACE,
      S_RESPOND
   } state_type;

   localparam int ID_W    = 6;
   localparam int KEY_W   = 4;
   localparam int ENTRY_W = ID_W + KEY_W;

   // One stored entry as it sits in the memory word.
   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      op_type      operation;
      logic [5:0]  position;
      logic [5:0]  entry_id;
      logic [3:0]  entry_key;
      logic [6:0]  sort_length;
   } req_type;

   typedef struct packed {
      logic [5:0]  out_id;
      logic [3:0]  out_key;
      status_type  status;
      logic [6:0]  fill_count;
      logic        is_empty;
   } rsp_type;

endpackage

>>> src/ilsort_ram.sv
// Generic single-write, single-read memory with registered read data.
module ilsort_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> src/indexed_list_store_with_sort.sv
// Insert and erase shift the entries between the position and the end of the list, one entry
// moved per cycle through the single memory port pair.
// Sort fetches each leading entry in turn and moves it toward the front one position at a time.
// One request is in flight at a time; the next beat is taken once the response is loaded.
// Reset clears the fill count and control state; memory contents are not cleared.
module indexed_list_store_with_sort #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ilsort_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ilsort_pkg::rsp_type rsp_data
);

   import ilsort_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // Sequencer and datapath registers.
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   op_type           op_ff, op_in;
   logic [AW-1:0]    pos_ff, pos_in;
   entry_type        new_ff, new_in;
   entry_type        out_ff, out_in;
   status_type       status_ff, status_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [AW-1:0]    j_ff, j_in;
   entry_type        hold_ff, hold_in;
   logic [AW-1:0]    src_ff, src_in;
   logic [AW-1:0]    stop_ff, stop_in;
   logic [AW-1:0]    wr_ff, wr_in;
   logic             up_ff, up_in;
   logic             more_ff, more_in;
   logic             pend_ff, pend_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Memory port signals.
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [AW-1:0]    ram_raddr;
   entry_type        ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   entry_type        rd_entry;

   // Request decode helpers.
   logic             accept;
   logic [XW-1:0]    pos_x;
   logic [XW-1:0]    cnt_x;
   logic [XW-1:0]    slen_x;
   logic [CW-1:0]    cnt_dec;
   logic             is_full;
   logic             pos_ok;
   status_type       req_status;
   logic             rsp_free;
   logic             hold_less;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign pos_x     = XW'(req_data.position);
   assign cnt_x     = XW'(count_ff);
   assign slen_x    = XW'(req_data.sort_length);
   assign cnt_dec   = count_ff - CW'(1);
   assign is_full   = (count_ff == CAP_C);
   assign pos_ok    = (pos_x < cnt_x);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rd_entry  = entry_type'(ram_rdata);
   assign hold_less = (hold_ff.key < rd_entry.key);

   // Status of the request beat against the current fill count.
   always_comb begin
      req_status = ST_OK;
      unique case (req_data.operation)
         OP_READ, OP_WRITE, OP_ERASE: req_status = pos_ok ? ST_OK : ST_BAD_INDEX;
         OP_INSERT: begin
            priority if (is_full) begin
               req_status = ST_FULL;
            end else if (!pos_ok) begin
               req_status = ST_BAD_INDEX;
            end else begin
               req_status = ST_OK;
            end
         end
         OP_APPEND: req_status = is_full ? ST_FULL : ST_OK;
         OP_POP:    req_status = (count_ff == '0) ? ST_EMPTY : ST_OK;
         default:   req_status = ST_OK;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RESPOND;
               if (req_status == ST_OK) begin
                  unique case (req_data.operation)
                     OP_READ, OP_ERASE, OP_POP: state_in = S_CAPTURE;
                     OP_INSERT:                 state_in = S_MOVE;
                     OP_SORT:                   state_in = S_SORT_FETCH;
                     default:                   state_in = S_RESPOND;
                  endcase
               end
            end
         end
         S_CAPTURE: state_in = (op_ff == OP_ERASE) ? S_MOVE : S_RESPOND;
         S_MOVE: begin
            if (!more_ff) begin
               state_in = up_ff ? S_PUT : S_RESPOND;
            end
         end
         S_PUT:        state_in = S_RESPOND;
         S_SORT_FETCH: state_in = (i_ff >= n_ff) ? S_RESPOND : S_SORT_HOLD;
         S_SORT_HOLD:  state_in = S_SORT_CMP;
         S_SORT_CMP: begin
            priority if (!hold_less) begin
               state_in = S_SORT_FETCH;
            end else if (j_ff == AW'(1)) begin
               state_in = S_SORT_PLACE;
            end else begin
               state_in = S_SORT_CMP;
            end
         end
         S_SORT_PLACE: state_in = S_SORT_FETCH;
         S_RESPOND: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory control and register next values.
   always_comb begin
      count_in     = count_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      new_in       = new_ff;
      out_in       = out_ff;
      status_in    = status_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      hold_in      = hold_ff;
      src_in       = src_ff;
      stop_in      = stop_ff;
      wr_in        = wr_ff;
      up_in        = up_ff;
      more_in      = more_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = new_ff;
      ram_raddr    = src_ff;

      unique case (state_ff)
         S_IDLE: begin
            ram_raddr = (req_data.operation == OP_POP) ? cnt_dec[AW-1:0] : pos_x[AW-1:0];
            ram_wdata = '{id: req_data.entry_id, key: req_data.entry_key};
            ram_waddr = (req_data.operation == OP_APPEND) ? count_ff[AW-1:0]
                                                         : pos_x[AW-1:0];
            if (accept) begin
               op_in     = req_data.operation;
               pos_in    = pos_x[AW-1:0];
               new_in    = '{id: req_data.entry_id, key: req_data.entry_key};
               out_in    = '0;
               status_in = req_status;
               // Insert walks down from the last entry to the insert position.
               src_in    = cnt_dec[AW-1:0];
               stop_in   = pos_x[AW-1:0];
               up_in     = 1'b1;
               more_in   = 1'b1;
               pend_in   = 1'b0;
               i_in      = CW'(1);
               n_in      = (slen_x < cnt_x) ? slen_x[CW-1:0] : count_ff;
               if (req_status == ST_OK) begin
                  unique case (req_data.operation)
                     OP_WRITE:  ram_we = 1'b1;
                     OP_APPEND: begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                     OP_POP:    count_in = cnt_dec;
                     default:   ram_we = 1'b0;
                  endcase
               end
            end
         end
         S_CAPTURE: begin
            out_in = rd_entry;
            // Erase walks up from the entry above the hole to the last entry.
            src_in  = pos_ff + AW'(1);
            stop_in = cnt_dec[AW-1:0];
            up_in   = 1'b0;
            more_in = (pos_ff != cnt_dec[AW-1:0]);
            pend_in = 1'b0;
         end
         S_MOVE: begin
            // Read one entry per cycle and write the previous read one slot over.
            ram_raddr = src_ff;
            ram_we    = pend_ff;
            ram_waddr = wr_ff;
            ram_wdata = rd_entry;
            if (more_ff) begin
               pend_in = 1'b1;
               wr_in   = up_ff ? (src_ff + AW'(1)) : (src_ff - AW'(1));
               if (src_ff == stop_ff) begin
                  more_in = 1'b0;
               end else begin
                  src_in = up_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
               end
            end else begin
               pend_in = 1'b0;
               if (!up_ff) begin
                  count_in = cnt_dec;
               end
            end
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = new_ff;
            count_in  = count_ff + CW'(1);
         end
         S_SORT_FETCH: begin
            ram_raddr = i_ff[AW-1:0];
         end
         S_SORT_HOLD: begin
            hold_in   = rd_entry;
            j_in      = i_ff[AW-1:0];
            ram_raddr = i_ff[AW-1:0] - AW'(1);
         end
         S_SORT_CMP: begin
            // The entry left of the hole is in the read data; shift it or drop the held one.
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_raddr = j_ff - AW'(2);
            if (hold_less) begin
               ram_wdata = rd_entry;
               j_in      = j_ff - AW'(1);
            end else begin
               ram_wdata = hold_ff;
               i_in      = i_ff + CW'(1);
            end
         end
         S_SORT_PLACE: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = hold_ff;
            i_in      = i_ff + CW'(1);
         end
         S_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_id      = out_ff.id;
               rsp_in.out_key     = out_ff.key;
               rsp_in.status      = status_ff;
               rsp_in.fill_count  = cnt_x[6:0];
               rsp_in.is_empty    = (count_ff == '0);
            end
         end
         default: ram_we = 1'b0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      new_ff    <= new_in;
      out_ff    <= out_in;
      status_ff <= status_in;
      i_ff      <= i_in;
      n_ff      <= n_in;
      j_ff      <= j_in;
      hold_ff   <= hold_in;
      src_ff    <= src_in;
      stop_ff   <= stop_in;
      wr_ff     <= wr_in;
      up_ff     <= up_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Entry memory: identifier and key share one word.
   ilsort_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

>>> tb/indexed_list_store_with_sort_test.sv
// Self-checking testbench for the indexed list store with sort: directed and random request beats.
module indexed_list_store_with_sort_test;
   import ilsort_pkg::*;

   localparam int CAPACITY      = 64;
   localparam int SMALL_FILL    = 12;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int STALL_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 16;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // How the random traffic steers the fill level.
   typedef enum {LOAD_STEADY, LOAD_CLIMB, LOAD_FULL, LOAD_DRAIN} workload_type;

   // Mirror of the list contents that predicts every response and checks the replies.
   class list_mirror;
      entry_type   slots [CAPACITY];
      int unsigned fill;
      rsp_type     awaited_replies [$];
      int unsigned mismatches;

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      // Applies one accepted request to the mirror and queues the reply it must produce.
      function void apply_request(req_type r);
         rsp_type     reply;
         entry_type   hold;
         int unsigned span;
         int          i;
         int          j;
         reply = '0;
         reply.status = ST_OK;
         case (r.operation)
            OP_READ: begin
               if (r.position >= fill) begin
                  reply.status = ST_BAD_INDEX;
               end else begin
                  reply.out_id  = slots[r.position].id;
                  reply.out_key = slots[r.position].key;
               end
            end
            OP_WRITE: begin
               if (r.position >= fill) begin
                  reply.status = ST_BAD_INDEX;
               end else begin
                  slots[r.position].id  = r.entry_id;
                  slots[r.position].key = r.entry_key;
               end
            end
            OP_INSERT: begin
               // A full list is reported before the index is looked at.
               if (fill >= CAPACITY) begin
                  reply.status = ST_FULL;
               end else if (r.position >= fill) begin
                  reply.status = ST_BAD_INDEX;
               end else begin
                  for (j = fill; j > r.position; j--) slots[j] = slots[j-1];
                  slots[r.position].id  = r.entry_id;
                  slots[r.position].key = r.entry_key;
                  fill++;
               end
            end
            OP_APPEND: begin
               if (fill >= CAPACITY) begin
                  reply.status = ST_FULL;
               end else begin
                  slots[fill].id  = r.entry_id;
                  slots[fill].key = r.entry_key;
                  fill++;
               end
            end
            OP_ERASE: begin
               if (r.position >= fill) begin
                  reply.status = ST_BAD_INDEX;
               end else begin
                  reply.out_id  = slots[r.position].id;
                  reply.out_key = slots[r.position].key;
                  for (j = r.position + 1; j < fill; j++) slots[j-1] = slots[j];
                  fill--;
               end
            end
            OP_POP: begin
               if (fill == 0) begin
                  reply.status = ST_EMPTY;
               end else begin
                  fill--;
                  reply.out_id  = slots[fill].id;
                  reply.out_key = slots[fill].key;
               end
            end
            OP_SORT: begin
               // Stable insertion sort by key over the leading entries, length clamped to fill.
               span = (r.sort_length < fill) ? r.sort_length : fill;
               for (i = 1; i < span; i++) begin
                  hold = slots[i];
                  j = i;
                  while (j > 0 && hold.key < slots[j-1].key) begin
                     slots[j] = slots[j-1];
                     j--;
                  end
                  slots[j] = hold;
               end
            end
            default: begin
               // The unused operation code changes nothing and reports ok.
            end
         endcase
         reply.fill_count = 7'(fill);
         reply.is_empty   = (fill == 0);
         awaited_replies.push_back(reply);
      endfunction

      function void compare_field(string field, logic [6:0] want, logic [6:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Checks one accepted response beat against the oldest queued reply.
      function void match_reply(rsp_type got);
         rsp_type want;
         if (awaited_replies.size() == 0) begin
            $display("%0t: reply mismatch: expected none, got id=%0d key=%0d status=%0d fill=%0d empty=%0d",
                     $time, got.out_id, got.out_key, got.status, got.fill_count, got.is_empty);
            mismatches++;
            return;
         end
         want = awaited_replies.pop_front();
         compare_field("out_id", 7'(want.out_id), 7'(got.out_id));
         compare_field("out_key", 7'(want.out_key), 7'(got.out_key));
         compare_field("status", 7'(want.status), 7'(got.status));
         compare_field("fill_count", want.fill_count, got.fill_count);
         compare_field("is_empty", 7'(want.is_empty), 7'(got.is_empty));
      endfunction
   endclass

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   rsp_type     rsp_data;
   logic        idle_enabled = 1'b1;
   int unsigned cycles_without_beat = 0;
   list_mirror  mirror = new();

   indexed_list_store_with_sort #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock with a period of 12.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The response side checks each accepted beat and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) mirror.match_reply(rsp_data);
         rsp_ready <= !(idle_enabled && $urandom_range(99) < 7);
      end
   end

   // Watchdog: the run ends if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         cycles_without_beat <= 0;
      end else if (cycles_without_beat >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         cycles_without_beat <= cycles_without_beat + 1;
      end
   end

   function automatic req_type beat_of(op_type op, int unsigned pos, int unsigned id,
                                       int unsigned key, int unsigned len);
      req_type r;
      r.operation   = op;
      r.position    = 6'(pos);
      r.entry_id    = 6'(id);
      r.entry_key   = 4'(key);
      r.sort_length = 7'(len);
      return r;
   endfunction

   // Draws a random request whose operation mix depends on the current workload.
   function automatic req_type next_random_request(int unsigned fill, workload_type load);
      req_type     r;
      int unsigned pick;
      r.entry_id  = 6'($urandom_range(63));
      r.entry_key = 4'($urandom_range(15));
      // Crowd the keys now and then so that equal keys exercise sort stability.
      if ($urandom_range(2) == 0) r.entry_key = 4'($urandom_range(2) * 7);
      if (fill != 0 && $urandom_range(9) != 0) r.position = 6'($urandom_range(fill - 1));
      else r.position = 6'($urandom_range(63));
      if ($urandom_range(7) == 0) r.sort_length = 7'($urandom_range(127));
      else r.sort_length = 7'($urandom_range(fill + 1));
      pick = $urandom_range(99);
      case (load)
         LOAD_CLIMB: begin
            if (pick < 70) r.operation = OP_APPEND;
            else if (pick < 80) r.operation = OP_INSERT;
            else if (pick < 88) r.operation = OP_READ;
            else if (pick < 95) r.operation = OP_WRITE;
            else r.operation = OP_SORT;
         end
         LOAD_FULL: begin
            if (pick < 15) r.operation = OP_APPEND;
            else if (pick < 35) r.operation = OP_INSERT;
            else if (pick < 50) r.operation = OP_READ;
            else if (pick < 65) r.operation = OP_WRITE;
            else if (pick < 80) r.operation = OP_ERASE;
            else if (pick < 88) r.operation = OP_SORT;
            else r.operation = OP_POP;
         end
         LOAD_DRAIN: begin
            if (pick < 50) r.operation = OP_POP;
            else if (pick < 80) r.operation = OP_ERASE;
            else if (pick < 90) r.operation = OP_READ;
            else r.operation = OP_WRITE;
         end
         default: begin
            if (pick < 14) r.operation = OP_READ;
            else if (pick < 26) r.operation = OP_WRITE;
            else if (pick < 40) r.operation = OP_INSERT;
            else if (pick < 54) r.operation = OP_APPEND;
            else if (pick < 68) r.operation = OP_ERASE;
            else if (pick < 80) r.operation = OP_POP;
            else if (pick < 96) r.operation = OP_SORT;
            else r.operation = op_type'(OP_UNUSED);
            // Keep the list short in steady traffic so that shifts and sorts stay cheap.
            if (fill > SMALL_FILL && r.operation == OP_INSERT) r.operation = OP_ERASE;
            if (fill > SMALL_FILL && r.operation == OP_APPEND) r.operation = OP_POP;
         end
      endcase
      return r;
   endfunction

   // Sends one request beat, optionally after a few idle cycles, and records it once accepted.
   // Valid is left high after acceptance so that back-to-back beats need no extra edge.
   task automatic send_request(input req_type r);
      while (idle_enabled && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      mirror.apply_request(r);
   endtask

   initial begin
      req_type      plan [$];
      workload_type load;
      int unsigned  issued;
      int unsigned  full_left;
      load = LOAD_STEADY;
      full_left = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: empty-list errors, extreme values, equal keys and sort clamping.
      plan.push_back(beat_of(OP_POP, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_READ, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_ERASE, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_WRITE, 0, 63, 15, 0));
      plan.push_back(beat_of(OP_INSERT, 0, 63, 15, 0));
      plan.push_back(beat_of(OP_SORT, 0, 0, 0, 64));
      plan.push_back(beat_of(op_type'(OP_UNUSED), 63, 63, 15, 127));
      plan.push_back(beat_of(OP_APPEND, 0, 63, 15, 0));
      plan.push_back(beat_of(OP_APPEND, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_APPEND, 0, 42, 15, 0));
      plan.push_back(beat_of(OP_INSERT, 1, 21, 7, 0));
      plan.push_back(beat_of(OP_INSERT, 4, 5, 5, 0));
      plan.push_back(beat_of(OP_READ, 63, 0, 0, 0));
      plan.push_back(beat_of(OP_WRITE, 3, 17, 7, 0));
      plan.push_back(beat_of(OP_SORT, 0, 0, 0, 1));
      plan.push_back(beat_of(OP_SORT, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_SORT, 0, 0, 0, 127));
      plan.push_back(beat_of(OP_READ, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_READ, 3, 0, 0, 0));
      plan.push_back(beat_of(OP_ERASE, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_ERASE, 2, 0, 0, 0));
      plan.push_back(beat_of(OP_POP, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_POP, 0, 0, 0, 0));
      plan.push_back(beat_of(OP_ERASE, 0, 0, 0, 0));
      foreach (plan[k]) send_request(plan[k]);

      // Random traffic; every few hundred beats the list is filled to capacity and drained.
      for (issued = 0; issued < RANDOM_ITEMS; issued++) begin
         if (issued % 350 == 100) load = LOAD_CLIMB;
         if (load == LOAD_CLIMB && mirror.fill == CAPACITY) begin
            load = LOAD_FULL;
            full_left = 30;
         end
         if (load == LOAD_FULL) begin
            if (full_left == 0) load = LOAD_DRAIN;
            else full_left--;
         end
         if (load == LOAD_DRAIN && mirror.fill <= 4) load = LOAD_STEADY;
         // A long stretch in the middle runs with no idling on either side.
         idle_enabled <= !(issued >= 500 && issued < 800);
         send_request(next_random_request(mirror.fill, load));
      end
      req_valid <= 1'b0;

      // Wait for the remaining replies, then a little longer to catch any stray beat.
      while (mirror.awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ilsort_pkg.sv
src/ilsort_ram.sv
src/indexed_list_store_with_sort.sv
tb/indexed_list_store_with_sort_test.sv
